// ===== src/proximity_weighted_speed_limit_top_assert.svh =====
// assertion macros for the proximity weighted speed limit block
`ifndef PROXIMITY_WEIGHTED_SPEED_LIMIT_TOP_ASSERT_SVH
`define PROXIMITY_WEIGHTED_SPEED_LIMIT_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define PWSL_ASSERT_IMP(label, lhs, rhs, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (lhs) |-> (rhs)) \
        else $error(msg);
// non-overlapping implication, checked outside reset
`define PWSL_ASSERT_NEXT(label, lhs, rhs, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (lhs) |=> (rhs)) \
        else $error(msg);
`endif

// ===== src/pwsl_pkg.sv =====
// shared types and constants for the proximity weighted speed limit block
package pwsl_pkg;
    localparam int FRAC_BITS = 16;
    localparam int CFG_W = 31;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOFTCAP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LETHAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd5;

    // operation handed from front to back
    typedef struct packed {
        logic        empty;
        logic        last;
        logic        do_blend;
        logic        do_block;
        logic [31:0] vdist;
        logic signed [31:0] cost;
    } pwsl_op_t;
endpackage

// ===== src/pwsl_fifo.sv =====
// two-entry queue between front and back
module pwsl_fifo import pwsl_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     wr_en,
    input  pwsl_op_t wr_data,
    output logic     full,
    input  logic     rd_en,
    output pwsl_op_t rd_data,
    output logic     not_empty
);
    pwsl_op_t   mem [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign rd_data = mem[rp_reg];

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end
endmodule

// ===== src/pwsl_front.sv =====
// front: distance by iterative square root and vertex classification
module pwsl_front import pwsl_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_empty,
    input  logic signed [31:0] in_x,
    input  logic signed [31:0] in_y,
    input  logic signed [31:0] in_cost,
    input  logic              in_inf,
    input  logic              in_lethal,
    input  logic              in_last,
    input  logic [CFG_W-1:0]  thr,
    input  logic [CFG_W-1:0]  min_d,
    input  logic [CFG_W-1:0]  softcap,
    input  logic [CFG_W-1:0]  lethal,
    input  logic [CFG_W-1:0]  offset,
    output logic              op_valid,
    output pwsl_op_t          op,
    input  logic              op_full
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ = 3'd1;
    localparam logic [2:0] S_SUM = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_OUT = 3'd4;

    logic [2:0]  state_reg;
    logic [4:0]  step_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic [65:0] rem_reg;
    logic [63:0] res_reg;
    logic [63:0] sq_x_reg, sq_y_reg;
    logic        empty_reg, last_reg, inf_reg, leth_reg;
    logic signed [31:0] cost_reg;
    logic signed [32:0] ay;
    logic [63:0] bit_v;
    logic [65:0] trial;
    logic [63:0] d64;
    logic        far, near_t;

    // |y| held in 33 bits; the offset is taken off when dy_reg is loaded
    assign ay = in_y[31] ? -$signed({in_y[31], in_y}) : $signed({in_y[31], in_y});
    assign bit_v = 64'd1 << {step_reg, 1'b0};
    assign trial = {2'b0, res_reg} + {2'b0, bit_v};
    assign d64 = res_reg;
    assign far = d64 > {33'd0, min_d};
    assign near_t = (thr != '0) && (d64 < {33'd0, thr});
    assign in_ready = state_reg == S_IDLE;

    always_comb begin
        op = '0;
        op.empty = empty_reg;
        op.last = last_reg;
        op.vdist = d64[31:0];
        op.cost = inf_reg ? $signed({1'b0, lethal}) : cost_reg;
        if (!empty_reg && far) begin
            if (inf_reg) begin
                if (leth_reg) begin
                    if (d64 < {33'd0, softcap}) op.do_block = 1'b1;
                    else op.do_blend = near_t;
                end
            end else begin
                op.do_blend = near_t;
            end
        end
    end
    assign op_valid = state_reg == S_OUT && !op_full;

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            dx_reg <= {in_x[31], in_x};
            dy_reg <= ay - $signed({2'b0, offset});
            empty_reg <= in_empty;
            last_reg <= in_last;
            inf_reg <= in_inf;
            leth_reg <= in_lethal;
            cost_reg <= in_cost;
        end
        if (state_reg == S_SQ) begin
            sq_x_reg <= 64'(dx_reg * dx_reg);
            sq_y_reg <= 64'(dy_reg * dy_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (in_valid) state_reg <= S_SQ;
                end
                S_SQ: begin
                    state_reg <= empty_reg ? S_OUT : S_SUM;
                end
                S_SUM: begin
                    // each square is at most 2^62, so the sum fits 64 bits
                    rem_reg <= {2'b0, sq_x_reg + sq_y_reg};
                    res_reg <= '0;
                    step_reg <= 5'd31;
                    state_reg <= S_ROOT;
                end
                S_ROOT: begin
                    if (rem_reg >= trial) begin
                        rem_reg <= rem_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_v;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    if (step_reg == 5'd0) state_reg <= S_OUT;
                    else step_reg <= step_reg - 5'd1;
                end
                S_OUT: begin
                    if (!op_full) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== src/pwsl_back.sv =====
// back: blend fold with sequential divider, speed output and result register
module pwsl_back import pwsl_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             op_avail,
    input  pwsl_op_t         op,
    output logic             op_take,
    input  logic [CFG_W-1:0] thr,
    input  logic [CFG_W-1:0] gain,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [63:0]      m_data
);
    `include "proximity_weighted_speed_limit_top_assert.svh"

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_MUL = 3'd1;
    localparam logic [2:0] B_DIV = 3'd2;
    localparam logic [2:0] B_FIN = 3'd3;
    localparam logic [2:0] B_SPD = 3'd4;
    localparam logic [2:0] B_OUT = 3'd5;
    localparam logic [2:0] B_LOAD = 3'd6;
    localparam logic [2:0] B_EMIT = 3'd7;

    logic [2:0]  st_reg;
    logic signed [31:0] acc_reg;
    logic        blk_reg;
    pwsl_op_t    op_reg;
    logic signed [63:0] p1_reg, p2_reg;
    logic        neg_reg;
    logic [64:0] num_reg;
    logic [64:0] quo_reg;
    logic [31:0] drem_reg;
    logic [6:0]  cnt_reg;
    logic signed [32:0] tmd;
    logic signed [64:0] sum;
    logic [32:0] shrem;
    logic signed [65:0] q_s;
    logic signed [63:0] prod_reg;
    logic signed [63:0] fl;
    logic signed [64:0] s;
    logic [30:0] spd;
    logic [63:0] out_next;
    logic        out_go;

    assign tmd = $signed({2'b0, thr}) - $signed({1'b0, op_reg.vdist});
    assign sum = 65'(p1_reg) + 65'(p2_reg);
    assign shrem = {drem_reg, num_reg[64]};
    assign q_s = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign fl = prod_reg >>> FRAC_BITS;
    assign s = (65'sd1 <<< FRAC_BITS) - 65'(fl);
    assign spd = s < 0 ? 31'd0 : (s > 65'sh7fffffff ? 31'h7fffffff : s[30:0]);
    assign out_next = blk_reg ? {1'b1, 32'h7fffffff, 31'd0} : {1'b0, acc_reg, spd};
    assign op_take = st_reg == B_IDLE && op_avail;
    assign m_valid = st_reg == B_OUT;

    always_ff @(posedge aclk) begin
        if (op_take) op_reg <= op;
        if (st_reg == B_MUL) begin
            p1_reg <= 64'(acc_reg) * $signed({32'd0, op_reg.vdist});
            p2_reg <= 64'(op_reg.cost) * 64'(tmd);
        end
        if (st_reg == B_SPD) prod_reg <= $signed({33'd0, gain}) * 64'(acc_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= B_IDLE;
            acc_reg <= '0;
            blk_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            case (st_reg)
                B_IDLE: begin
                    if (op_avail) begin
                        if (op.empty) begin
                            acc_reg <= '0;
                            blk_reg <= 1'b0;
                            m_data <= '0;
                            st_reg <= B_OUT;
                        end else if (op.do_blend) st_reg <= B_MUL;
                        else begin
                            if (op.do_block) blk_reg <= 1'b1;
                            st_reg <= op.last ? B_SPD : B_IDLE;
                        end
                    end
                end
                B_MUL: st_reg <= B_LOAD;
                B_DIV: begin
                    // restoring division of |num| by threshold, one bit a cycle
                    if (shrem >= {2'b0, thr}) begin
                        drem_reg <= 32'(shrem - {2'b0, thr});
                        quo_reg <= {quo_reg[63:0], 1'b1};
                    end else begin
                        drem_reg <= shrem[31:0];
                        quo_reg <= {quo_reg[63:0], 1'b0};
                    end
                    num_reg <= {num_reg[63:0], 1'b0};
                    if (cnt_reg == 7'd0) st_reg <= B_FIN;
                    else cnt_reg <= cnt_reg - 7'd1;
                end
                B_FIN: begin
                    if (q_s > 66'sh7fffffff) acc_reg <= 32'h7fffffff;
                    else if (q_s < -66'sh80000000) acc_reg <= 32'h80000000;
                    else acc_reg <= q_s[31:0];
                    st_reg <= op_reg.last ? B_SPD : B_IDLE;
                end
                B_SPD: st_reg <= B_EMIT;
                B_OUT: begin
                    if (m_ready) begin
                        st_reg <= B_IDLE;
                    end
                end
                B_LOAD: begin
                    // load divider after product registers settle
                    neg_reg <= sum[64];
                    num_reg <= sum[64] ? 65'(-sum) : sum;
                    quo_reg <= '0;
                    drem_reg <= '0;
                    cnt_reg <= 7'd64;
                    st_reg <= B_DIV;
                end
                B_EMIT: begin
                    m_data <= out_next;
                    acc_reg <= '0;
                    blk_reg <= 1'b0;
                    st_reg <= B_OUT;
                end
                default: st_reg <= B_IDLE;
            endcase
        end
    end

    assign out_go = m_valid && m_ready;

    `PWSL_ASSERT_NEXT(a_out_clears, out_go, !m_valid, "result held after accept")
    `PWSL_ASSERT_IMP(a_no_take_busy, op_take, st_reg == B_IDLE, "op taken while busy")
    `PWSL_ASSERT_NEXT(a_spd_state, st_reg == B_SPD, st_reg == B_EMIT, "speed step lost")
endmodule

// ===== src/proximity_weighted_speed_limit_top.sv =====
// proximity weighted speed limit: one vertex per item, one speed per frame
// s_ channel: one mesh vertex per item; tlast marks the last vertex of a frame,
//   tuser carries empty_frame, cost_infinite and is_lethal
// m_ channel: one result per frame (on tlast or on an empty frame item)
// cfg port: write enable, index and 31-bit value, taken at once
// front part: squares, then their sum, then a bit-pair square root of 32 steps;
//   an empty frame item skips to the output, and no vertex is taken while busy
// back part: a blending vertex goes through the products, the divider load and
//   the one-bit-a-cycle divider by the threshold; other vertices are handled in idle
// an empty frame item goes from the queue straight to the result; a last vertex
//   goes on, after its blend if it blends, through the speed and emit steps
// a two-entry queue sits between the parts so the front runs ahead
// reset sets the configuration registers to their defaults and empties the queue and state
// when m_tready is low the result is held and the back stalls; the front
//   fills the queue and then drops s_tready
module proximity_weighted_speed_limit_top import pwsl_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // pos_x, pos_y, vertex_cost
    input  logic [2:0]  s_tuser,   // empty_frame, cost_infinite, is_lethal
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // speed, weighted_cost, blocked
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [30:0] cfg_wdata
);
    logic [CFG_W-1:0] thr_reg, min_reg, soft_reg, leth_reg, gain_reg, off_reg;
    logic     f_valid, q_full, q_avail, q_take;
    pwsl_op_t f_op, q_op;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= 31'd655360;
            min_reg <= 31'd6554;
            soft_reg <= 31'd0;
            leth_reg <= 31'd655360;
            gain_reg <= 31'd6554;
            off_reg <= 31'd32768;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_THRESHOLD: thr_reg <= cfg_wdata;
                REG_MIN_DIST:  min_reg <= cfg_wdata;
                REG_SOFTCAP:   soft_reg <= cfg_wdata;
                REG_LETHAL:    leth_reg <= cfg_wdata;
                REG_GAIN:      gain_reg <= cfg_wdata;
                REG_OFFSET:    off_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    pwsl_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_empty(s_tuser[0]),
        .in_x(s_tdata[31:0]), .in_y(s_tdata[63:32]), .in_cost(s_tdata[95:64]),
        .in_inf(s_tuser[1]), .in_lethal(s_tuser[2]), .in_last(s_tlast),
        .thr(thr_reg), .min_d(min_reg), .softcap(soft_reg),
        .lethal(leth_reg), .offset(off_reg),
        .op_valid(f_valid), .op(f_op), .op_full(q_full)
    );

    pwsl_fifo u_fifo (
        .aclk, .aresetn,
        .wr_en(f_valid), .wr_data(f_op), .full(q_full),
        .rd_en(q_take), .rd_data(q_op), .not_empty(q_avail)
    );

    pwsl_back u_back (
        .aclk, .aresetn,
        .op_avail(q_avail), .op(q_op), .op_take(q_take),
        .thr(thr_reg), .gain(gain_reg),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_data(m_tdata)
    );
endmodule
